// File: rtl/d2f_pkg.sv
// shared types, constants and elaboration helpers for the decimal to fixed-point parser
// no dependencies

package d2f_pkg;

    localparam int FRAC_DIGITS_DEF = 8;
    localparam int FIX_W = 63;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_DOT,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } char_item_t;

    typedef enum logic [1:0] {
        PH_INT  = 2'b01,
        PH_FRAC = 2'b10
    } phase_t;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        int i;
        p = 64'd1;
        for (i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic int bits_for(input logic [63:0] v);
        int n;
        int i;
        n = 1;
        for (i = 1; i < 64; i++) begin
            if ((v >> i) != 64'd0) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/d2f_front.sv
// front end: classifies one input character into digit, dot, other or none
// depends on d2f_pkg

module d2f_front import d2f_pkg::*; (
    input  logic [7:0] char_byte,
    input  logic       char_valid,
    input  logic       last,
    output char_item_t item
);

    always_comb begin
        item.last  = last;
        item.digit = 4'(char_byte - CHAR_ZERO);
        priority if (!char_valid) begin
            item.cls = CLS_NONE;
        end else if (char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE) begin
            item.cls = CLS_DIGIT;
        end else if (char_byte == CHAR_DOT) begin
            item.cls = CLS_DOT;
        end else begin
            item.cls = CLS_OTHER;
        end
    end

endmodule

// File: rtl/d2f_queue.sv
// short queue of classified characters between front end and back end
// depends on d2f_pkg

module d2f_queue import d2f_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  char_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       q_valid,
    output char_item_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    char_item_t       entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/d2f_back.sv
// back end: accumulates digits, then scales, range-checks and registers the result
// depends on d2f_pkg

module d2f_back import d2f_pkg::*; #(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  char_item_t       head,
    output logic             pop,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [FIX_W-1:0] m_fixed_value,
    output logic             m_parse_ok
);

    localparam logic [63:0] SCALE      = pow10(FRAC_DIGITS);
    localparam logic [63:0] INT_LIMIT  = INT64_TOP / SCALE;
    localparam logic [63:0] FRAC_LIMIT = INT64_TOP % SCALE;
    localparam int INT_W   = bits_for(INT_LIMIT * 64'd10 + 64'd9);
    localparam int FRAC_W  = bits_for(SCALE - 64'd1);
    localparam int SCALE_W = bits_for(SCALE);
    localparam int CNT_W   = bits_for(64'(FRAC_DIGITS));
    localparam int PROD_W  = INT_W + SCALE_W;
    localparam int PADP_W  = FRAC_W + SCALE_W;

    localparam logic [INT_W-1:0]   INT_LIM_N  = INT_W'(INT_LIMIT);
    localparam logic [FRAC_W-1:0]  FRAC_LIM_N = FRAC_W'(FRAC_LIMIT);
    localparam logic [SCALE_W-1:0] SCALE_N    = SCALE_W'(SCALE);

    // parse state
    logic [INT_W-1:0]  int_reg, int_next, ex_int;
    logic [FRAC_W-1:0] frac_reg, frac_next, ex_frac;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, ex_cnt;
    logic              seen_reg, seen_next, ex_seen;
    logic              err_reg, err_next, ex_err;
    phase_t            phase_reg, phase_next, ex_phase;

    logic advance;
    logic fin;
    logic ex_ok;

    // pipeline
    logic              p1_valid_reg, p1_ok_reg;
    logic [INT_W-1:0]  p1_int_reg;
    logic [FRAC_W-1:0] p1_frac_reg;
    logic [CNT_W-1:0]  p1_cnt_reg;

    logic              p2_valid_reg, p2_ok_reg, p2_int_gt_reg, p2_int_eq_reg;
    logic [PROD_W-1:0] p2_int_scaled_reg;
    logic [FRAC_W-1:0] p2_frac_pad_reg;

    logic              m_valid_reg, m_parse_ok_reg;
    logic [FIX_W-1:0]  m_fixed_value_reg;

    logic [SCALE_W-1:0] pad_tab [2**CNT_W];
    logic [PROD_W-1:0]  int_prod;
    logic [PADP_W-1:0]  pad_prod;
    logic               frac_gt;
    logic               ok_final;

    genvar k;
    generate
        for (k = 0; k < 2**CNT_W; k++) begin : g_pad
            localparam logic [SCALE_W-1:0] PAD_K =
                (k <= FRAC_DIGITS) ? SCALE_W'(pow10(FRAC_DIGITS - k)) : SCALE_W'(1);
            assign pad_tab[k] = PAD_K;
        end
    endgenerate

    assign advance = !m_valid_reg || m_ready;
    assign pop     = q_valid && (!head.last || advance);
    assign fin     = pop && head.last;

    // character update
    always_comb begin
        ex_int   = int_reg;
        ex_frac  = frac_reg;
        ex_cnt   = cnt_reg;
        ex_seen  = seen_reg;
        ex_err   = err_reg;
        ex_phase = phase_reg;
        if (pop && head.cls != CLS_NONE && !err_reg) begin
            unique case (phase_reg)
                PH_INT: begin
                    unique case (head.cls)
                        CLS_DIGIT: begin
                            if (int_reg > INT_LIM_N) begin
                                ex_err = 1'b1;
                            end else begin
                                ex_int  = (int_reg << 3) + (int_reg << 1) + INT_W'(head.digit);
                                ex_seen = 1'b1;
                            end
                        end
                        CLS_DOT: begin
                            if (!seen_reg) begin
                                ex_err = 1'b1;
                            end else begin
                                ex_phase = PH_FRAC;
                            end
                        end
                        default: ex_err = 1'b1;
                    endcase
                end
                PH_FRAC: begin
                    if (head.cls == CLS_DIGIT) begin
                        if (cnt_reg >= CNT_W'(FRAC_DIGITS)) begin
                            ex_err = 1'b1;
                        end else begin
                            ex_frac = (frac_reg << 3) + (frac_reg << 1) + FRAC_W'(head.digit);
                            ex_cnt  = cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        ex_err = 1'b1;
                    end
                end
                default: ex_err = 1'b1;
            endcase
        end
        ex_ok = !ex_err && ex_seen && !(ex_phase == PH_FRAC && ex_cnt == '0);
    end

    // end of string returns to the idle parse state
    always_comb begin
        if (fin) begin
            int_next   = '0;
            frac_next  = '0;
            cnt_next   = '0;
            seen_next  = 1'b0;
            err_next   = 1'b0;
            phase_next = PH_INT;
        end else begin
            int_next   = ex_int;
            frac_next  = ex_frac;
            cnt_next   = ex_cnt;
            seen_next  = ex_seen;
            err_next   = ex_err;
            phase_next = ex_phase;
        end
    end

    assign int_prod = PROD_W'(p1_int_reg) * PROD_W'(SCALE_N);
    assign pad_prod = PADP_W'(p1_frac_reg) * PADP_W'(pad_tab[p1_cnt_reg]);

    assign frac_gt  = (p2_frac_pad_reg > FRAC_LIM_N);
    assign ok_final = p2_ok_reg && !p2_int_gt_reg && !(p2_int_eq_reg && frac_gt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_reg      <= '0;
            frac_reg     <= '0;
            cnt_reg      <= '0;
            seen_reg     <= 1'b0;
            err_reg      <= 1'b0;
            phase_reg    <= PH_INT;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
            phase_reg <= phase_next;
            if (advance) begin
                p1_valid_reg <= fin;
                p2_valid_reg <= p1_valid_reg;
                m_valid_reg  <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_ok_reg         <= ex_ok;
            p1_int_reg        <= ex_int;
            p1_frac_reg       <= ex_frac;
            p1_cnt_reg        <= ex_cnt;
            p2_ok_reg         <= p1_ok_reg;
            p2_int_scaled_reg <= int_prod;
            p2_frac_pad_reg   <= pad_prod[FRAC_W-1:0];
            p2_int_gt_reg     <= (p1_int_reg > INT_LIM_N);
            p2_int_eq_reg     <= (p1_int_reg == INT_LIM_N);
            m_parse_ok_reg    <= ok_final;
            m_fixed_value_reg <= ok_final ?
                FIX_W'(p2_int_scaled_reg) + FIX_W'(p2_frac_pad_reg) : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fixed_value = m_fixed_value_reg;
    assign m_parse_ok    = m_parse_ok_reg;

endmodule

// File: rtl/decimal_to_fixed8_parser_core.sv
// top level of the decimal string to fixed-point parser
// depends on d2f_pkg, d2f_front, d2f_queue, d2f_back

// usage:
//   the s_ channel takes one request per character: s_char_byte with
//   s_char_valid, and s_last on the final character of a string. a request
//   with s_char_valid low adds nothing; with s_last high it still ends the string.
//   the m_ channel gives one result per string: m_parse_ok and m_fixed_value,
//   the value times 10^FRAC_DIGITS, zero when the string is rejected.
//   throughput: one request per cycle while s_ready is high, set by the
//   times-ten accumulator update in the back end.
//   the result shows on m_valid once the last request has passed the
//   queue, parse, scaling multiply, and add and range check registers.
//   a stalled m_ready holds the result register and the scaling pipeline;
//   characters that do not end a string keep draining from the two-entry
//   queue, and s_ready drops only once the queue is full.
//   reset (aresetn low, synchronous) empties the queue and pipeline and
//   returns the parser to the start of a string.

module decimal_to_fixed8_parser_core import d2f_pkg::*; #(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_char_byte,
    input  logic             s_char_valid,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [FIX_W-1:0] m_fixed_value,
    output logic             m_parse_ok
);

    char_item_t front_item;
    char_item_t head;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    logic       push;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    d2f_front u_front (
        .char_byte  (s_char_byte),
        .char_valid (s_char_valid),
        .last       (s_last),
        .item       (front_item)
    );

    d2f_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    d2f_back #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_fixed_value (m_fixed_value),
        .m_parse_ok    (m_parse_ok)
    );

endmodule

// File: rtl/d2f_checker.sv
// port-level checks for the parser, with the bind that attaches them to the top level
// depends on d2f_pkg and decimal_to_fixed8_parser_core

module d2f_checker import d2f_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [7:0]       s_char_byte,
    input logic             s_char_valid,
    input logic             s_last,
    input logic             m_valid,
    input logic             m_ready,
    input logic [FIX_W-1:0] m_fixed_value,
    input logic             m_parse_ok
);

    localparam int PEND_MAX = QUEUE_DEPTH + 3;
    localparam int PEND_W   = $clog2(PEND_MAX + 2);

    // strings accepted whose result is not yet taken
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              last_in;
    logic              res_out;

    assign last_in = s_valid && s_ready && s_last;
    assign res_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (last_in && !res_out) begin
            pending_next = pending_reg + PEND_W'(1);
        end else if (res_out && !last_in) begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fixed_value) && $stable(m_parse_ok))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_parse_ok |-> m_fixed_value == '0)
        else $error("rejected string carries a nonzero value");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != '0)
        else $error("result without a finished string");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(PEND_MAX))
        else $error("more strings in flight than the pipeline holds");

endmodule

bind decimal_to_fixed8_parser_core d2f_checker u_checker (.*);
